// ===== design/chca_pkg.sv =====
// ----------------------------------------------------------------------------
// chca_pkg: shared definitions for the canonical Huffman code assigner
// Field widths, request codes and parameter defaults.
// ----------------------------------------------------------------------------
package chca_pkg;

    localparam int SYM_W       = 8;
    localparam int LEN_W       = 5;
    localparam int CODE_W      = 24;
    localparam int RUN_W       = 32;
    localparam int NUM_LENGTHS = 32;

    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;

    localparam int DEF_MAX_SYMBOLS  = 256;
    localparam int DEF_MAX_CODE_LEN = 24;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

endpackage

// ===== design/canonical_huffman_code_assigner.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_code_assigner: canonical code assignment over a symbol set
// Loads collect symbol lengths, a counting-sort pass orders the set by
// length and symbol, and fetches return symbols with their canonical codes.
// ----------------------------------------------------------------------------
// A fetch result passes through the sorted-memory read register and then into
// the output registers, held back while the output is stalled; s_tready is low meanwhile.
// After the final load: a drain state, a prefix-sum pass over the 32-entry length
// histogram and a placement scan of all MAX_SYMBOLS symbols, with s_tready low.
// Reset: a clearing pass over all MAX_SYMBOLS entries of the length
// memory runs with s_tready low before the first load is taken.
module canonical_huffman_code_assigner #(
    parameter int MAX_SYMBOLS  = chca_pkg::DEF_MAX_SYMBOLS,
    parameter int MAX_CODE_LEN = chca_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [chca_pkg::S_TDATA_W-1:0]  s_tdata,  // symbol[7:0], length[12:8]
    input  logic                            s_tlast,  // final_req
    input  logic                            s_tuser,  // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [chca_pkg::M_TDATA_W-1:0]  m_tdata,  // out_symbol[7:0], code[31:8],
                                                      // code_length[36:32]
    output logic                            m_tlast,  // last
    output logic                            m_tuser   // error
);

    localparam int AW    = $clog2(MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int LW    = chca_pkg::LEN_W;
    localparam int SW    = chca_pkg::SYM_W;
    localparam int NL    = chca_pkg::NUM_LENGTHS;
    localparam int KW    = $clog2(NL);
    localparam int LMW   = LW + 1;
    localparam int SMW   = LW + SW;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_LOAD,
        ST_DRAIN,
        ST_PREFIX,
        ST_SCAN,
        ST_READY,
        ST_FETCH,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              sc_cnt_reg;
    logic                       sc_issue_reg;
    logic                       sc_v_reg;
    logic [AW-1:0]              sc_addr_reg;
    logic                       s1_valid_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic [LW-1:0]              s1_len_reg;
    logic                       fwd_reg;
    logic [LW-1:0]              fwd_len_reg;
    logic [CW-1:0]              hist_reg [NL];
    logic [CW-1:0]              hist_next [NL];
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic [KW-1:0]              pf_k_reg;
    logic [CW-1:0]              pf_acc_reg;
    logic [CW-1:0]              cursor_reg;
    logic [chca_pkg::RUN_W-1:0] run_reg;
    logic [LW-1:0]              cur_len_reg;
    logic                       m_tvalid_reg;
    logic [SW-1:0]              out_sym_reg;
    logic [chca_pkg::CODE_W-1:0] out_code_reg;
    logic [LW-1:0]              out_len_reg;
    logic                       out_last_reg;
    logic                       out_err_reg;

    logic                       in_acc;
    logic                       load_acc;
    logic                       fetch_acc;
    logic                       set_clear;
    logic [SW-1:0]              sym_in;
    logic [LW-1:0]              len_in;
    logic                       sym_ok;
    logic [AW-1:0]              sym_addr;

    logic                       lm_we;
    logic [AW-1:0]              lm_waddr;
    logic [LMW-1:0]             lm_wdata;
    logic                       lm_re;
    logic [AW-1:0]              lm_raddr;
    logic [LMW-1:0]             lm_rdata;
    logic                       old_present;
    logic [LW-1:0]              old_len;

    logic [KW-1:0]              hsel;
    logic [CW-1:0]              hval;

    logic                       sm_we;
    logic                       sm_re;
    logic [SMW-1:0]             sm_rdata;
    logic                       cursor_ok;

    logic [SW-1:0]              f_sym;
    logic [LW-1:0]              f_len;
    logic                       f_err;
    logic                       f_grow;
    logic [chca_pkg::RUN_W-1:0] f_shifted;
    logic [CW-1:0]              cursor_inc;
    logic                       f_last;
    logic                       out_free;

    assign s_tready  = state_reg inside {ST_LOAD, ST_READY, ST_DONE};
    assign in_acc    = s_tvalid && s_tready;
    assign load_acc  = in_acc && (s_tuser == chca_pkg::CMD_LOAD);
    assign fetch_acc = in_acc && (s_tuser == chca_pkg::CMD_FETCH) && (state_reg == ST_READY);
    assign set_clear = load_acc && (state_reg != ST_LOAD);
    assign sym_in    = s_tdata[SW-1:0];
    assign len_in    = s_tdata[SW+LW-1:SW];
    assign sym_ok    = 32'(sym_in) < 32'(MAX_SYMBOLS);
    assign sym_addr  = AW'(sym_in);

    // length memory: {present, length} per symbol
    assign lm_re    = (load_acc && sym_ok) || ((state_reg == ST_SCAN) && sc_issue_reg);
    assign lm_raddr = (state_reg == ST_SCAN) ? sc_cnt_reg : sym_addr;
    assign lm_we    = s1_valid_reg || sc_v_reg || (state_reg == ST_CLEAR);
    assign lm_waddr = s1_valid_reg ? s1_addr_reg : (sc_v_reg ? sc_addr_reg : sc_cnt_reg);
    assign lm_wdata = s1_valid_reg ? {1'b1, s1_len_reg} : '0;

    chca_ram #(
        .WIDTH (LMW),
        .DEPTH (MAX_SYMBOLS)
    ) u_len_ram (
        .clk   (clk),
        .we    (lm_we),
        .waddr (lm_waddr),
        .wdata (lm_wdata),
        .re    (lm_re),
        .raddr (lm_raddr),
        .rdata (lm_rdata)
    );

    assign old_present = fwd_reg || lm_rdata[LW];
    assign old_len     = fwd_reg ? fwd_len_reg : lm_rdata[LW-1:0];

    assign hsel = (state_reg == ST_PREFIX) ? pf_k_reg : lm_rdata[LW-1:0];
    assign hval = hist_reg[hsel];

    // sorted memory: {length, symbol} per sorted slot
    assign cursor_ok = cursor_reg < count_reg;
    assign sm_we     = sc_v_reg && lm_rdata[LW];
    assign sm_re     = fetch_acc && cursor_ok;

    chca_ram #(
        .WIDTH (SMW),
        .DEPTH (MAX_SYMBOLS)
    ) u_sort_ram (
        .clk   (clk),
        .we    (sm_we),
        .waddr (hval[AW-1:0]),
        .wdata ({lm_rdata[LW-1:0], SW'(sc_addr_reg)}),
        .re    (sm_re),
        .raddr (cursor_reg[AW-1:0]),
        .rdata (sm_rdata)
    );

    assign f_sym      = sm_rdata[SW-1:0];
    assign f_len      = sm_rdata[SMW-1:SW];
    assign f_err      = f_len > LW'(MAX_CODE_LEN);
    assign f_grow     = f_len > cur_len_reg;
    assign f_shifted  = f_grow ? (run_reg << (f_len - cur_len_reg)) : run_reg;
    assign cursor_inc = cursor_reg + CW'(1);
    assign f_last     = cursor_inc >= count_reg;
    assign out_free   = !m_tvalid_reg || m_tready;

    always_comb
    begin
        hist_next  = hist_reg;
        count_next = count_reg;
        if (set_clear)
        begin
            for (int i = 0; i < NL; i++)
            begin
                hist_next[i] = '0;
            end
            count_next = '0;
        end
        else if (s1_valid_reg)
        begin
            for (int i = 0; i < NL; i++)
            begin
                hist_next[i] = hist_reg[i] + CW'(s1_len_reg == LW'(i))
                               - CW'(old_present && (old_len == LW'(i)));
            end
            if (!old_present)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (state_reg == ST_PREFIX)
        begin
            hist_next[pf_k_reg] = pf_acc_reg;
        end
        else if (sm_we)
        begin
            hist_next[hsel] = hval + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            sc_cnt_reg   <= '0;
            sc_issue_reg <= 1'b0;
            sc_v_reg     <= 1'b0;
            sc_addr_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_addr_reg  <= '0;
            s1_len_reg   <= '0;
            fwd_reg      <= 1'b0;
            fwd_len_reg  <= '0;
            for (int i = 0; i < NL; i++)
            begin
                hist_reg[i] <= '0;
            end
            count_reg    <= '0;
            pf_k_reg     <= '0;
            pf_acc_reg   <= '0;
            cursor_reg   <= '0;
            run_reg      <= '0;
            cur_len_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            out_sym_reg  <= '0;
            out_code_reg <= '0;
            out_len_reg  <= '0;
            out_last_reg <= 1'b0;
            out_err_reg  <= 1'b0;
        end
        else
        begin
            hist_reg     <= hist_next;
            count_reg    <= count_next;
            s1_valid_reg <= load_acc && sym_ok;
            fwd_reg      <= load_acc && s1_valid_reg && (s1_addr_reg == sym_addr);
            sc_v_reg     <= (state_reg == ST_SCAN) && sc_issue_reg;
            m_tvalid_reg <= ((state_reg == ST_FETCH) && out_free)
                            || (m_tvalid_reg && !m_tready);

            case (state_reg)
                ST_CLEAR:
                begin
                    if (sc_cnt_reg == AW'(MAX_SYMBOLS - 1))
                    begin
                        sc_cnt_reg <= '0;
                        state_reg  <= ST_LOAD;
                    end
                    else
                    begin
                        sc_cnt_reg <= sc_cnt_reg + AW'(1);
                    end
                end
                ST_LOAD, ST_READY, ST_DONE:
                begin
                    if (load_acc)
                    begin
                        s1_addr_reg  <= sym_addr;
                        s1_len_reg   <= len_in;
                        fwd_len_reg  <= s1_len_reg;
                        state_reg    <= s_tlast ? ST_DRAIN : ST_LOAD;
                    end
                    else if (fetch_acc)
                    begin
                        state_reg <= cursor_ok ? ST_FETCH : ST_DONE;
                    end
                end
                ST_DRAIN:
                begin
                    pf_k_reg   <= '0;
                    pf_acc_reg <= '0;
                    state_reg  <= ST_PREFIX;
                end
                ST_PREFIX:
                begin
                    pf_acc_reg <= pf_acc_reg + hval;
                    pf_k_reg   <= pf_k_reg + 1'b1;
                    if (pf_k_reg == KW'(NL - 1))
                    begin
                        sc_cnt_reg   <= '0;
                        sc_issue_reg <= 1'b1;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (sc_issue_reg)
                    begin
                        sc_addr_reg <= sc_cnt_reg;
                        if (sc_cnt_reg == AW'(MAX_SYMBOLS - 1))
                        begin
                            sc_issue_reg <= 1'b0;
                        end
                        else
                        begin
                            sc_cnt_reg <= sc_cnt_reg + AW'(1);
                        end
                    end
                    else if (sc_v_reg)
                    begin
                        cursor_reg  <= '0;
                        run_reg     <= '0;
                        cur_len_reg <= '0;
                        state_reg   <= ST_READY;
                    end
                end
                ST_FETCH:
                begin
                    if (out_free)
                    begin
                        out_sym_reg  <= f_sym;
                        out_len_reg  <= f_len;
                        if (f_err)
                        begin
                            out_code_reg <= '0;
                            out_last_reg <= 1'b1;
                            out_err_reg  <= 1'b1;
                            state_reg    <= ST_DONE;
                        end
                        else
                        begin
                            out_code_reg <= f_shifted[chca_pkg::CODE_W-1:0];
                            out_last_reg <= f_last;
                            out_err_reg  <= 1'b0;
                            run_reg      <= f_shifted + 1'b1;
                            cur_len_reg  <= f_grow ? f_len : cur_len_reg;
                            cursor_reg   <= cursor_inc;
                            state_reg    <= f_last ? ST_DONE : ST_READY;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_code_reg, out_sym_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("error result without last");

    a_load_scan_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && sc_v_reg))
        else $error("load update overlaps placement scan");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READY || state_reg == ST_FETCH) |-> cursor_reg <= count_reg)
        else $error("fetch cursor beyond symbol count");

    a_fetch_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) && !$past(state_reg == ST_FETCH)
        |-> $past(state_reg == ST_READY) && $past(cursor_reg < count_reg))
        else $error("fetch read issued outside ready state");

endmodule

// ===== design/chca_ram.sv =====
// ----------------------------------------------------------------------------
// chca_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module chca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== dv/canonical_huffman_code_assigner_test.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_code_assigner_test: stream-level test of the code assigner
// Sends load and fetch requests through the input stream and checks every
// fetched symbol, code, length, last and error flag against an in-bench
// model of the counting sort and canonical code assignment.
// ----------------------------------------------------------------------------
module canonical_huffman_code_assigner_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW          = chca_pkg::SYM_W;
    localparam int LW          = chca_pkg::LEN_W;
    localparam int CDW         = chca_pkg::CODE_W;
    localparam int NLEN        = chca_pkg::NUM_LENGTHS;
    localparam int MAX_SYMS    = chca_pkg::DEF_MAX_SYMBOLS;
    localparam int MAX_LEN     = chca_pkg::DEF_MAX_CODE_LEN;
    localparam int ITEM_TARGET = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = chca_pkg::DEF_MAX_SYMBOLS + 64;

    typedef enum logic [1:0] {SET_LOADING, SET_READY, SET_DONE} set_phase_t;

    typedef struct packed {
        logic [SW-1:0]  sym;
        logic [CDW-1:0] code;
        logic [LW-1:0]  len;
        logic           last;
        logic           err;
    } code_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [chca_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [chca_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;

    // code model state
    logic [LW-1:0]                  sym_len [MAX_SYMS];
    bit                             sym_present [MAX_SYMS];
    int unsigned                    len_hist [NLEN];
    logic [SW-1:0]                  sorted_syms [MAX_SYMS];
    int unsigned                    set_size;
    logic [chca_pkg::RUN_W-1:0]     next_code;
    logic [LW-1:0]                  code_len_now;
    int unsigned                    fetch_pos;
    set_phase_t                     set_phase;

    code_result_t      pending_codes [$];
    int unsigned       sent_items;
    int unsigned       mismatches;
    int unsigned       cycles;
    bit                src_steady;
    bit                sink_steady;
    int unsigned       sink_hold_request;

    canonical_huffman_code_assigner dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void clear_set();
        for (int i = 0; i < MAX_SYMS; i++)
        begin
            sym_present[i] = 1'b0;
        end
        for (int i = 0; i < NLEN; i++)
        begin
            len_hist[i] = 0;
        end
        set_size     = 0;
        next_code    = '0;
        code_len_now = '0;
        fetch_pos    = 0;
        set_phase    = SET_LOADING;
    endfunction

    function automatic void sort_set();
        int unsigned slot [NLEN];
        int unsigned acc;
        acc = 0;
        for (int l = 0; l < NLEN; l++)
        begin
            slot[l] = acc;
            acc += len_hist[l];
        end
        for (int s = 0; s < MAX_SYMS; s++)
        begin
            if (sym_present[s])
            begin
                if (slot[sym_len[s]] < MAX_SYMS)
                begin
                    sorted_syms[slot[sym_len[s]]] = s[SW-1:0];
                end
                slot[sym_len[s]]++;
            end
        end
        fetch_pos    = 0;
        next_code    = '0;
        code_len_now = '0;
        set_phase    = SET_READY;
    endfunction

    function automatic void predict_code(input logic cmd, input logic [SW-1:0] sym,
                                         input logic [LW-1:0] len, input logic fin);
        code_result_t res;
        logic [SW-1:0] s;
        logic [LW-1:0] l;
        if (cmd == chca_pkg::CMD_LOAD)
        begin
            if (set_phase != SET_LOADING)
            begin
                clear_set();
            end
            if (sym_present[sym])
            begin
                len_hist[sym_len[sym]]--;
            end
            else
            begin
                sym_present[sym] = 1'b1;
                set_size++;
            end
            sym_len[sym] = len;
            len_hist[len]++;
            if (fin)
            begin
                sort_set();
            end
            return;
        end
        if (set_phase != SET_READY)
        begin
            return;
        end
        if (fetch_pos >= set_size)
        begin
            set_phase = SET_DONE;
            return;
        end
        s = sorted_syms[fetch_pos];
        l = sym_len[s];
        res.sym = s;
        res.len = l;
        if (l > MAX_LEN)
        begin
            res.code  = '0;
            res.last  = 1'b1;
            res.err   = 1'b1;
            set_phase = SET_DONE;
            pending_codes.push_back(res);
            return;
        end
        if (l > code_len_now)
        begin
            next_code    = next_code << (l - code_len_now);
            code_len_now = l;
        end
        res.code = next_code[CDW-1:0];
        res.err  = 1'b0;
        next_code++;
        fetch_pos++;
        res.last = (fetch_pos >= set_size);
        if (res.last)
        begin
            set_phase = SET_DONE;
        end
        pending_codes.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 200)
        begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
        end
    endtask

    function automatic int source_gap();
        int r;
        if (src_steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [LW-1:0] pick_length(input bit allow_err);
        if (allow_err && $urandom_range(0, 7) == 0)
        begin
            return LW'($urandom_range(MAX_LEN + 1, 31));
        end
        return LW'($urandom_range(0, MAX_LEN));
    endfunction

    task automatic send_request(input logic cmd, input logic [SW-1:0] sym,
                                input logic [LW-1:0] len, input logic fin);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(chca_pkg::S_TDATA_W - SW - LW){1'b0}}, len, sym};
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent_items++;
        predict_code(cmd, sym, len, fin);
    endtask

    task automatic send_fetch();
        send_request(chca_pkg::CMD_FETCH, SW'($urandom), LW'($urandom), 1'($urandom));
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sink side: random stalls, plus long hold-offs on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_request > 0)
            begin
                stall_left        = sink_hold_request;
                sink_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (sink_steady || $urandom_range(0, 9) < 7)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready   <= 1'b0;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        code_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata[31:0], 0);
            end
            else
            begin
                want = pending_codes.pop_front();
                if (m_tdata[7:0] != want.sym)
                begin
                    report_mismatch("out_symbol", 32'(m_tdata[7:0]), 32'(want.sym));
                end
                if (m_tdata[31:8] != want.code)
                begin
                    report_mismatch("code", 32'(m_tdata[31:8]), 32'(want.code));
                end
                if (m_tdata[36:32] != want.len)
                begin
                    report_mismatch("code_length", 32'(m_tdata[36:32]), 32'(want.len));
                end
                if (m_tlast != want.last)
                begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
                if (m_tuser != want.err)
                begin
                    report_mismatch("error", 32'(m_tuser), 32'(want.err));
                end
            end
        end
    end

    task automatic test_sorted_set();
        send_request(chca_pkg::CMD_LOAD, 8'd0,   5'd3,  1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd255, 5'd3,  1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd7,   5'd0,  1'b0);
        send_fetch();
        send_request(chca_pkg::CMD_LOAD, 8'd128, 5'd24, 1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd64,  5'd1,  1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd64,  5'd0,  1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd200, 5'd1,  1'b1);
        repeat (7) send_fetch();
        wait_drain();
    endtask

    task automatic test_length_error();
        send_request(chca_pkg::CMD_LOAD, 8'd5,  5'd31, 1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd9,  5'd4,  1'b0);
        send_request(chca_pkg::CMD_LOAD, 8'd3,  5'd25, 1'b1);
        repeat (3) send_fetch();
        send_request(chca_pkg::CMD_LOAD, 8'd17, 5'd26, 1'b1);
        repeat (2) send_fetch();
        wait_drain();
    endtask

    task automatic test_backpressure();
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        for (int i = 0; i < 48; i++)
        begin
            send_request(chca_pkg::CMD_LOAD, SW'(i * 5), LW'($urandom_range(1, MAX_LEN)),
                         i == 47);
        end
        sink_hold_request = 400;
        repeat (48) send_fetch();
        wait_drain();
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    task automatic test_random_sets();
        int unsigned perm [MAX_SYMS];
        int unsigned tmp;
        int n;
        int pick;
        int r;
        int nfetch;
        bit allow_err;
        while (sent_items < ITEM_TARGET)
        begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 39);
            if (r < 28)
            begin
                n = $urandom_range(1, 8);
            end
            else if (r < 38)
            begin
                n = $urandom_range(9, 48);
            end
            else
            begin
                n = $urandom_range(120, MAX_SYMS);
            end
            for (int i = 0; i < MAX_SYMS; i++)
            begin
                perm[i] = i;
            end
            for (int i = 0; i < n; i++)
            begin
                pick       = $urandom_range(i, MAX_SYMS - 1);
                tmp        = perm[i];
                perm[i]    = perm[pick];
                perm[pick] = tmp;
            end
            allow_err = ($urandom_range(0, 5) == 0);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_fetch();
                end
                if (i > 0 && $urandom_range(0, 9) == 0)
                begin
                    send_request(chca_pkg::CMD_LOAD, SW'(perm[$urandom_range(0, i - 1)]),
                                 pick_length(allow_err), 1'b0);
                end
                send_request(chca_pkg::CMD_LOAD, SW'(perm[i]), pick_length(allow_err),
                             i == n - 1);
            end
            nfetch = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1)
                                                 : n + $urandom_range(0, 2);
            repeat (nfetch) send_fetch();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin
        sent_items        = 0;
        mismatches        = 0;
        src_steady        = 1'b0;
        sink_steady       = 1'b0;
        sink_hold_request = 0;
        clear_set();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_sorted_set();
        test_length_error();
        test_backpressure();
        test_random_sets();
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (pending_codes.size() != 0)
        begin
            report_mismatch("results never delivered", pending_codes.size(), 0);
        end
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
